// ===== hw/rtl/phong_palette_entry_defines.svh =====
// Assertion macros shared by the phong palette entry RTL.
// Needs a clock named clock and a synchronous reset named reset in the including module.
`ifndef PHONG_PALETTE_ENTRY_DEFINES_SVH
`define PHONG_PALETTE_ENTRY_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PPE_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define PPE_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ppe_pkg.sv =====
// Package for the phong palette entry block: sizes, register indexes, stage types
// and the quarter-wave cosine table built at elaboration. No dependencies.
package ppe_pkg;

   // Palette and table sizes
   localparam int MAX_COLORS      = 256;
   localparam int COS_TABLE_DEPTH = 1024;
   localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
   localparam int SLOT_W          = $clog2(COS_TABLE_DEPTH + 1);

   // Field widths
   localparam int IDX_W    = 8;
   localparam int STEP_W   = 17;
   localparam int ANGLE_W  = 17;
   localparam int PROD_W   = IDX_W + STEP_W;
   localparam int SLOT_PROD_W = ANGLE_W + SLOT_W;
   localparam int COS_W    = 16;
   localparam int DIFF_W   = 5;
   localparam int SPEC_W   = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // Angle and channel limits
   localparam int QUARTER_TURN = 65536;
   localparam int RED_MAX      = 31;
   localparam int GREEN_MAX    = 63;
   localparam int BLUE_MAX     = 31;
   localparam logic [STEP_W-1:0] ANGLE_STEP_RESET = STEP_W'(QUARTER_TURN / MAX_COLORS);

   // Series constants for the table, Q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] SERIES_DIV [1:11] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306,
        64'd380, 64'd462};

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIFFUSE_RED    = 3'd0,
      CSR_SPECULAR_RED   = 3'd1,
      CSR_DIFFUSE_GREEN  = 3'd2,
      CSR_SPECULAR_GREEN = 3'd3,
      CSR_DIFFUSE_BLUE   = 3'd4,
      CSR_SPECULAR_BLUE  = 3'd5,
      CSR_ANGLE_STEP     = 3'd6
   } csr_index_type;

   // Word entering and leaving the power pipeline
   typedef struct packed {
      logic             valid;
      logic [COS_W-1:0] c;
   } pwr_in_type;

   typedef struct packed {
      logic             valid;
      logic [COS_W-1:0] c;
      logic [COS_W-1:0] c12;
   } pwr_out_type;

   typedef logic [COS_W-1:0] cos_lut_type [COS_TABLE_DEPTH];

   // Cosine of entry k by an integer Taylor series in Q30, rounded to Q0.16
   function automatic logic [COS_W-1:0] series_cos(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        q16;
      logic signed [63:0] sum;
      logic [COS_W-1:0]   res;
      int                 n;
      x    = (64'(k) * HALF_PI_Q30) / COS_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      sum  = signed'(ONE_Q30);
      for (n = 1; n <= 11; n++) begin
         term = ((term * x2) >> 30) / SERIES_DIV[n];
         if (n[0]) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum <= 0) begin
         res = '0;
      end else begin
         q16 = (unsigned'(sum) + 64'd8192) >> 14;
         res = (q16 > 64'd65535) ? {COS_W{1'b1}} : q16[COS_W-1:0];
      end
      return res;
   endfunction

   function automatic cos_lut_type build_cos_lut();
      cos_lut_type lut;
      for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
         lut[k] = series_cos(k);
      end
      return lut;
   endfunction

   localparam cos_lut_type COS_LUT = build_cos_lut();

endpackage

// ===== hw/rtl/ppe_power.sv =====
// Four-stage pipeline that raises the Q0.16 cosine to the 12th power.
// Depends on ppe_pkg and phong_palette_entry_defines.svh.
`include "phong_palette_entry_defines.svh"

module ppe_power
   import ppe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  pwr_in_type  pwr_in,
   output pwr_out_type pwr_out
);

   logic [3:0]       valid_ff;
   logic [3:0]       valid_in;
   logic [COS_W-1:0] c_ff [4];
   logic [COS_W-1:0] c2_ff;
   logic [COS_W-1:0] c4_ff;
   logic [COS_W-1:0] c4b_ff;
   logic [COS_W-1:0] c8_ff;
   logic [COS_W-1:0] c12_ff;
   logic [2*COS_W-1:0] c2_in;
   logic [2*COS_W-1:0] c4_in;
   logic [2*COS_W-1:0] c8_in;
   logic [2*COS_W-1:0] c12_in;

   // Advance valid bits one stage a cycle
   assign valid_in = {valid_ff[2:0], pwr_in.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // One squaring or product per stage, truncated back to Q0.16
   assign c2_in  = (2*COS_W)'(pwr_in.c) * (2*COS_W)'(pwr_in.c);
   assign c4_in  = (2*COS_W)'(c2_ff) * (2*COS_W)'(c2_ff);
   assign c8_in  = (2*COS_W)'(c4_ff) * (2*COS_W)'(c4_ff);
   assign c12_in = (2*COS_W)'(c8_ff) * (2*COS_W)'(c4b_ff);

   always_ff @(posedge clock) begin
      c_ff[0] <= pwr_in.c;
      c_ff[1] <= c_ff[0];
      c_ff[2] <= c_ff[1];
      c_ff[3] <= c_ff[2];
      c2_ff   <= c2_in[2*COS_W-1:COS_W];
      c4_ff   <= c4_in[2*COS_W-1:COS_W];
      c4b_ff  <= c4_ff;
      c8_ff   <= c8_in[2*COS_W-1:COS_W];
      c12_ff  <= c12_in[2*COS_W-1:COS_W];
   end

   assign pwr_out.valid = valid_ff[3];
   assign pwr_out.c     = c_ff[3];
   assign pwr_out.c12   = c12_ff;

   // A power of a fraction never exceeds the fraction
   `PPE_ASSERT_IMPLY(a_pwr_bound, pwr_out.valid, pwr_out.c12 <= pwr_out.c, "c12 above c")
   `PPE_ASSERT_IMPLY(a_pwr_zero, pwr_out.valid && (pwr_out.c == '0), pwr_out.c12 == '0,
      "c12 nonzero for zero cosine")
   `PPE_ASSERT_ALWAYS(a_pwr_latency, pwr_out.valid == $past(pwr_in.valid, 4),
      "power pipeline lost or invented a word")

endmodule

// ===== hw/rtl/phong_palette_entry.sv =====
// Phong palette entry: palette index in, one RGB565 ramp colour out.
// Depends on ppe_pkg, ppe_power and phong_palette_entry_defines.svh.
//
// Use:
//   Request: raise start with req_color_index; the word is taken at a rising edge
//   where start is high and busy is low. busy is low except while reset is high,
//   so one word can be taken every cycle.
//   Response: rsp_valid is high for one cycle with rsp_packed_color (red 15-11,
//   green 10-5, blue 4-0). Words come out in request order.
//   Throughput: one word per cycle; the stages are the index-times-step multiply,
//   the registered cosine table read, four squaring/product stages and the
//   channel weighting with saturation.
//   Configuration: csr_we, csr_index, csr_wdata write one register per edge;
//   write only while no word is in flight. Indexes beyond angle_step are ignored.
//   Reset: synchronous, clears the pipeline valid bits, weights go to zero and
//   angle_step to a quarter turn over the palette size.
//   The receiver cannot stall: each result is shown for exactly one cycle.
`include "phong_palette_entry_defines.svh"

module phong_palette_entry
   import ppe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [IDX_W-1:0]      req_color_index,
   output logic                  rsp_valid,
   output logic [15:0]           rsp_packed_color,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PIPE_LATENCY = 7;
   localparam int SUM_W = COS_W + SPEC_W + 1;

   logic [DIFF_W-1:0] diffuse_red_ff, diffuse_green_ff, diffuse_blue_ff;
   logic [SPEC_W-1:0] specular_red_ff, specular_green_ff, specular_blue_ff;
   logic [STEP_W-1:0] angle_step_ff;

   logic               in_fire;
   logic [PROD_W-1:0]  prod;
   logic [ANGLE_W-1:0] angle_in;
   logic [ANGLE_W-1:0] angle_ff;
   logic               s1_valid_ff;
   logic [SLOT_PROD_W-1:0] slot_prod;
   logic [SLOT_W-1:0]  slot;
   logic [COS_W-1:0]   rom_ff;
   logic               top_ff;
   logic               s2_valid_ff;
   pwr_in_type         pwr_in;
   pwr_out_type        pwr_out;
   logic [SUM_W-1:0]   red_sum, green_sum, blue_sum;
   logic [6:0]         red_lvl, green_lvl, blue_lvl;
   logic [15:0]        color_in;
   logic [15:0]        color_ff;
   logic               out_valid_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         diffuse_red_ff    <= '0;
         specular_red_ff   <= '0;
         diffuse_green_ff  <= '0;
         specular_green_ff <= '0;
         diffuse_blue_ff   <= '0;
         specular_blue_ff  <= '0;
         angle_step_ff     <= ANGLE_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIFFUSE_RED:    diffuse_red_ff    <= csr_wdata[DIFF_W-1:0];
            CSR_SPECULAR_RED:   specular_red_ff   <= csr_wdata[SPEC_W-1:0];
            CSR_DIFFUSE_GREEN:  diffuse_green_ff  <= csr_wdata[DIFF_W-1:0];
            CSR_SPECULAR_GREEN: specular_green_ff <= csr_wdata[SPEC_W-1:0];
            CSR_DIFFUSE_BLUE:   diffuse_blue_ff   <= csr_wdata[DIFF_W-1:0];
            CSR_SPECULAR_BLUE:  specular_blue_ff  <= csr_wdata[SPEC_W-1:0];
            CSR_ANGLE_STEP:     angle_step_ff     <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Take a word every cycle outside reset
   assign busy    = reset;
   assign in_fire = start & ~busy;

   // Stage 1: angle = quarter turn minus index * step, clamped at zero
   assign prod     = PROD_W'(req_color_index) * PROD_W'(angle_step_ff);
   assign angle_in = (prod > PROD_W'(QUARTER_TURN)) ? '0
                   : ANGLE_W'(PROD_W'(QUARTER_TURN) - prod);

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   // Stage 2: cosine table read, a full quarter turn reads as zero
   assign slot_prod = SLOT_PROD_W'(angle_ff) * SLOT_PROD_W'(COS_TABLE_DEPTH);
   assign slot      = SLOT_W'(slot_prod >> 16);

   always_ff @(posedge clock) begin
      rom_ff <= COS_LUT[slot[COS_IDX_W-1:0]];
      top_ff <= (slot == SLOT_W'(COS_TABLE_DEPTH));
   end

   assign pwr_in.valid = s2_valid_ff;
   assign pwr_in.c     = top_ff ? '0 : rom_ff;

   // Stages 3 to 6: c to the 12th
   ppe_power u_power (
      .clock   (clock),
      .reset   (reset),
      .pwr_in  (pwr_in),
      .pwr_out (pwr_out)
   );

   // Stage 7: weight, saturate and pack the channels
   assign red_sum   = SUM_W'(diffuse_red_ff) * SUM_W'(pwr_out.c)
                    + SUM_W'(specular_red_ff) * SUM_W'(pwr_out.c12);
   assign green_sum = SUM_W'(diffuse_green_ff) * SUM_W'(pwr_out.c)
                    + SUM_W'(specular_green_ff) * SUM_W'(pwr_out.c12);
   assign blue_sum  = SUM_W'(diffuse_blue_ff) * SUM_W'(pwr_out.c)
                    + SUM_W'(specular_blue_ff) * SUM_W'(pwr_out.c12);

   assign red_lvl   = red_sum[SUM_W-1:16];
   assign green_lvl = green_sum[SUM_W-1:16];
   assign blue_lvl  = blue_sum[SUM_W-1:16];

   always_comb begin
      color_in[15:11] = (red_lvl > 7'(RED_MAX)) ? 5'(RED_MAX) : red_lvl[4:0];
      color_in[10:5]  = (green_lvl > 7'(GREEN_MAX)) ? 6'(GREEN_MAX) : green_lvl[5:0];
      color_in[4:0]   = (blue_lvl > 7'(BLUE_MAX)) ? 5'(BLUE_MAX) : blue_lvl[4:0];
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
   end

   // Valid bits for the stages kept in this module
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_fire;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= pwr_out.valid;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_packed_color = color_ff;

   // Each taken word leaves exactly once
   `PPE_ASSERT_ALWAYS(a_latency, rsp_valid == $past(in_fire, PIPE_LATENCY),
      "response does not match request timing")
   // Index zero sits at a quarter turn, so its colour is black
   `PPE_ASSERT_IMPLY(a_index_zero_black,
      rsp_valid && $past(in_fire && (req_color_index == '0), PIPE_LATENCY),
      rsp_packed_color == '0, "index zero not black")
   `PPE_ASSERT_IMPLY(a_slot_range, s1_valid_ff, slot <= SLOT_W'(COS_TABLE_DEPTH),
      "table slot beyond a quarter turn")

endmodule
